@@ rtl/core/pcp_pkg.sv @@
// Shared types and constants for the pulse coincidence pairer.
// Used by every module of the block but pcp_store; depends on nothing else.
`timescale 1ns / 1ps

package pcp_pkg;

    localparam int WIN_W        = 14;
    localparam int OUT_IDX_W    = 6;
    localparam int RESULT_LIMIT = 32;
    localparam int RES_CNT_W    = 6;
    localparam int OUT_DATA_W   = 16;
    localparam int OUT_USER_W   = 2;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 14'd3;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_START,
        ST_FETCH_I,
        ST_LATCH_I,
        ST_FETCH_J,
        ST_CMP,
        ST_FINISH
    } pcp_state_t;

    typedef struct packed {
        logic                 pair_valid;
        logic [OUT_IDX_W-1:0] first_index;
        logic [OUT_IDX_W-1:0] second_index;
        logic                 overflow;
        logic                 last_result;
    } pcp_result_t;

endpackage

@@ rtl/core/pcp_store.sv @@
// Pulse store: one word per pulse holding the matched flag and the peak time.
// One write port and one registered read port; depends on nothing else.
`timescale 1ns / 1ps

module pcp_store #(
    parameter int MAX_PULSES = 64,
    parameter int TIME_BITS  = 14,
    parameter int IDX_W      = 6
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  logic [TIME_BITS:0]   wr_data,
    input  logic [IDX_W-1:0]     rd_addr,
    output logic [TIME_BITS:0]   rd_data
);

    logic [TIME_BITS:0] mem [MAX_PULSES];
    logic [TIME_BITS:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/pcp_window_cmp.sv @@
// Shared window compare unit: absolute time difference against the window.
// Depends on pcp_pkg for the window width.
`timescale 1ns / 1ps

module pcp_window_cmp #(
    parameter int TIME_BITS = 14
) (
    input  logic [TIME_BITS-1:0]        a,
    input  logic [TIME_BITS-1:0]        b,
    input  logic [pcp_pkg::WIN_W-1:0]   window,
    output logic                        hit
);

    localparam int CMP_W = (TIME_BITS > pcp_pkg::WIN_W) ? TIME_BITS : pcp_pkg::WIN_W;

    logic [TIME_BITS-1:0] diff;

    always_comb
    begin
        if (a >= b)
        begin
            diff = a - b;
        end
        else
        begin
            diff = b - a;
        end
        hit = CMP_W'(diff) < CMP_W'(window);
    end

endmodule

@@ rtl/core/pcp_out_stage.sv @@
// Output register for result beats, packing the result into stream fields.
// Depends on pcp_pkg for the result type and field widths.
`timescale 1ns / 1ps

module pcp_out_stage (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  pcp_pkg::pcp_result_t                result,
    output logic                                free,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [pcp_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic [pcp_pkg::OUT_USER_W-1:0]      m_axis_tuser,
    output logic                                m_axis_tlast
);

    logic                 valid_reg;
    logic                 valid_next;
    pcp_pkg::pcp_result_t res_reg;
    pcp_pkg::pcp_result_t res_next;

    assign free = !valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (push)
        begin
            valid_next = 1'b1;
            res_next   = result;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {{(pcp_pkg::OUT_DATA_W - 2 * pcp_pkg::OUT_IDX_W){1'b0}},
                            res_reg.second_index, res_reg.first_index};
    assign m_axis_tuser  = {res_reg.overflow, res_reg.pair_valid};
    assign m_axis_tlast  = res_reg.last_result;

endmodule

@@ rtl/core/pcp_seq.sv @@
// Sequencer: loads pulses, then walks the pairs through the shared compare unit.
// Depends on pcp_pkg; drives pcp_store, pcp_window_cmp and pcp_out_stage.
`timescale 1ns / 1ps

module pcp_seq #(
    parameter int MAX_PULSES = 64,
    parameter int TIME_BITS  = 14,
    parameter int IDX_W      = 6,
    parameter int CNT_W      = 7
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [TIME_BITS-1:0]    in_time,
    input  logic                    in_last,
    output logic [IDX_W-1:0]        rd_addr,
    input  logic [TIME_BITS:0]      rd_data,
    output logic                    wr_en,
    output logic [IDX_W-1:0]        wr_addr,
    output logic [TIME_BITS:0]      wr_data,
    output logic [TIME_BITS-1:0]    cmp_a,
    output logic [TIME_BITS-1:0]    cmp_b,
    input  logic                    hit,
    input  logic                    out_free,
    output logic                    push,
    output pcp_pkg::pcp_result_t    result
);

    pcp_pkg::pcp_state_t state_reg;
    pcp_pkg::pcp_state_t state_next;

    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic                          ovf_reg;
    logic                          ovf_next;
    logic [pcp_pkg::RES_CNT_W-1:0] n_reg;
    logic [pcp_pkg::RES_CNT_W-1:0] n_next;
    logic                          pend_valid_reg;
    logic                          pend_valid_next;
    logic [IDX_W-1:0]              i_reg;
    logic [IDX_W-1:0]              i_next;
    logic [IDX_W-1:0]              j_reg;
    logic [IDX_W-1:0]              j_next;
    logic [TIME_BITS-1:0]          a_reg;
    logic [TIME_BITS-1:0]          a_next;
    logic [IDX_W-1:0]              pend_first_reg;
    logic [IDX_W-1:0]              pend_first_next;
    logic [IDX_W-1:0]              pend_second_reg;
    logic [IDX_W-1:0]              pend_second_next;

    logic             rd_matched;
    logic             match;
    logic             stall;
    logic             last_i;
    logic             last_j;
    logic             at_limit;
    logic [CNT_W-1:0] i_plus2;
    logic [CNT_W-1:0] j_plus1;

    assign rd_matched = rd_data[TIME_BITS];
    assign cmp_a      = a_reg;
    assign cmp_b      = rd_data[TIME_BITS-1:0];
    assign match      = hit && !rd_matched;
    assign stall      = pend_valid_reg && !out_free;
    assign i_plus2    = CNT_W'(i_reg) + CNT_W'(2);
    assign j_plus1    = CNT_W'(j_reg) + CNT_W'(1);
    assign last_i     = i_plus2 >= count_reg;
    assign last_j     = j_plus1 == count_reg;
    assign at_limit   = (n_reg + pcp_pkg::RES_CNT_W'(1))
                        == pcp_pkg::RES_CNT_W'(pcp_pkg::RESULT_LIMIT);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pcp_pkg::ST_LOAD:
            begin
                if (in_valid && in_last)
                begin
                    state_next = pcp_pkg::ST_START;
                end
            end
            pcp_pkg::ST_START:
            begin
                if (count_reg < CNT_W'(2))
                begin
                    state_next = pcp_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = pcp_pkg::ST_FETCH_I;
                end
            end
            pcp_pkg::ST_FETCH_I:
            begin
                state_next = pcp_pkg::ST_LATCH_I;
            end
            pcp_pkg::ST_LATCH_I:
            begin
                if (!rd_matched)
                begin
                    state_next = pcp_pkg::ST_FETCH_J;
                end
                else if (last_i)
                begin
                    state_next = pcp_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = pcp_pkg::ST_FETCH_I;
                end
            end
            pcp_pkg::ST_FETCH_J:
            begin
                state_next = pcp_pkg::ST_CMP;
            end
            pcp_pkg::ST_CMP:
            begin
                if (match)
                begin
                    if (!stall)
                    begin
                        if (at_limit || last_i)
                        begin
                            state_next = pcp_pkg::ST_FINISH;
                        end
                        else
                        begin
                            state_next = pcp_pkg::ST_FETCH_I;
                        end
                    end
                end
                else if (!last_j)
                begin
                    state_next = pcp_pkg::ST_FETCH_J;
                end
                else if (last_i)
                begin
                    state_next = pcp_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = pcp_pkg::ST_FETCH_I;
                end
            end
            pcp_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = pcp_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = pcp_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        count_next       = count_reg;
        ovf_next         = ovf_reg;
        n_next           = n_reg;
        pend_valid_next  = pend_valid_reg;
        i_next           = i_reg;
        j_next           = j_reg;
        a_next           = a_reg;
        pend_first_next  = pend_first_reg;
        pend_second_next = pend_second_reg;
        in_ready         = 1'b0;
        rd_addr          = j_reg;
        wr_en            = 1'b0;
        wr_addr          = count_reg[IDX_W-1:0];
        wr_data          = {1'b0, in_time};
        push             = 1'b0;
        result           = '0;
        result.overflow  = ovf_reg;
        case (state_reg)
            pcp_pkg::ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (count_reg < CNT_W'(MAX_PULSES))
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            pcp_pkg::ST_START:
            begin
                i_next = '0;
            end
            pcp_pkg::ST_FETCH_I:
            begin
                rd_addr = i_reg;
            end
            pcp_pkg::ST_LATCH_I:
            begin
                a_next = rd_data[TIME_BITS-1:0];
                j_next = IDX_W'(i_reg + IDX_W'(1));
                if (rd_matched)
                begin
                    i_next = IDX_W'(i_reg + IDX_W'(1));
                end
            end
            pcp_pkg::ST_FETCH_J:
            begin
                rd_addr = j_reg;
            end
            pcp_pkg::ST_CMP:
            begin
                if (match)
                begin
                    if (!stall)
                    begin
                        // Only the later pulse is flagged; the earlier one is never read again.
                        wr_en   = 1'b1;
                        wr_addr = j_reg;
                        wr_data = {1'b1, rd_data[TIME_BITS-1:0]};
                        if (pend_valid_reg)
                        begin
                            push                = 1'b1;
                            result.pair_valid   = 1'b1;
                            result.first_index  = pcp_pkg::OUT_IDX_W'(pend_first_reg);
                            result.second_index = pcp_pkg::OUT_IDX_W'(pend_second_reg);
                        end
                        pend_valid_next  = 1'b1;
                        pend_first_next  = i_reg;
                        pend_second_next = j_reg;
                        n_next           = n_reg + pcp_pkg::RES_CNT_W'(1);
                        i_next           = IDX_W'(i_reg + IDX_W'(1));
                    end
                end
                else if (!last_j)
                begin
                    j_next = IDX_W'(j_reg + IDX_W'(1));
                end
                else
                begin
                    i_next = IDX_W'(i_reg + IDX_W'(1));
                end
            end
            pcp_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    push               = 1'b1;
                    result.last_result = 1'b1;
                    if (pend_valid_reg)
                    begin
                        result.pair_valid   = 1'b1;
                        result.first_index  = pcp_pkg::OUT_IDX_W'(pend_first_reg);
                        result.second_index = pcp_pkg::OUT_IDX_W'(pend_second_reg);
                    end
                    count_next      = '0;
                    ovf_next        = 1'b0;
                    n_next          = '0;
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pcp_pkg::ST_LOAD;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg           <= i_next;
        j_reg           <= j_next;
        a_reg           <= a_next;
        pend_first_reg  <= pend_first_next;
        pend_second_reg <= pend_second_next;
    end

endmodule

@@ rtl/core/pulse_coincidence_pairer_core.sv @@
// Top level of the pulse coincidence pairer: window register and module wiring.
// Depends on pcp_pkg, pcp_store, pcp_window_cmp, pcp_seq and pcp_out_stage.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata: pulse_time; tlast: last_pulse
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: first_index, second_index;
//                                                tuser: pair_valid, overflow; tlast: last_result
//  cfg       in   cfg_we                         cfg_wdata: window_bins
//
// Each pulse beat offered in the load state is taken. A beat with tlast starts the search;
// the input stays blocked until it ends, and the one read port of the store sets its pace.
// Reset needs no clearing pass: match flags are cleared as each pulse is written.
// A stalled result beat holds in the output register; the search pauses on a new pair
// until the earlier one has been moved out, and the input stays blocked until then.
`timescale 1ns / 1ps

module pulse_coincidence_pairer_core #(
    parameter int MAX_PULSES = 64,
    parameter int TIME_BITS  = 14
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Fields from bit 0: pulse_time.
    input  logic [((TIME_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Fields from bit 0: first_index, second_index.
    output logic [pcp_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // Fields from bit 0: pair_valid, overflow.
    output logic [pcp_pkg::OUT_USER_W-1:0]      m_axis_tuser,
    output logic                                m_axis_tlast,
    input  logic                                cfg_we,
    input  logic [pcp_pkg::WIN_W-1:0]           cfg_wdata
);

    localparam int IDX_W = $clog2(MAX_PULSES);
    localparam int CNT_W = $clog2(MAX_PULSES + 1);

    logic [pcp_pkg::WIN_W-1:0] window_reg;
    logic [pcp_pkg::WIN_W-1:0] window_next;

    logic [IDX_W-1:0]     rd_addr;
    logic [TIME_BITS:0]   rd_data;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [TIME_BITS:0]   wr_data;
    logic [TIME_BITS-1:0] cmp_a;
    logic [TIME_BITS-1:0] cmp_b;
    logic                 hit;
    logic                 out_free;
    logic                 push;
    pcp_pkg::pcp_result_t result;

    assign window_next = cfg_we ? cfg_wdata : window_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= pcp_pkg::WINDOW_RESET;
        end
        else
        begin
            window_reg <= window_next;
        end
    end

    pcp_store #(
        .MAX_PULSES (MAX_PULSES),
        .TIME_BITS  (TIME_BITS),
        .IDX_W      (IDX_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pcp_window_cmp #(
        .TIME_BITS (TIME_BITS)
    ) u_cmp (
        .a      (cmp_a),
        .b      (cmp_b),
        .window (window_reg),
        .hit    (hit)
    );

    pcp_seq #(
        .MAX_PULSES (MAX_PULSES),
        .TIME_BITS  (TIME_BITS),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_time  (s_axis_tdata[TIME_BITS-1:0]),
        .in_last  (s_axis_tlast),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .cmp_a    (cmp_a),
        .cmp_b    (cmp_b),
        .hit      (hit),
        .out_free (out_free),
        .push     (push),
        .result   (result)
    );

    pcp_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .result        (result),
        .free          (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

@@ rtl/core/pcp_checker.sv @@
// Port-level checks for the pulse coincidence pairer, bound to the top level.
// Depends on pcp_pkg and pulse_coincidence_pairer_core.
`timescale 1ns / 1ps

module pcp_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                s_axis_tlast,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [pcp_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    input logic [pcp_pkg::OUT_USER_W-1:0]      m_axis_tuser,
    input logic                                m_axis_tlast
);

    // A stalled result beat keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result beat changed");

    // An empty result closes its event.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast)
        else $error("empty result without last");

    // An empty result carries zero indices.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("empty result with nonzero indices");

    // The last pulse of an event starts the search, so input is blocked next.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input taken during search");

endmodule

bind pulse_coincidence_pairer_core pcp_checker u_pcp_checker (.*);
